@@ sv/aac_pkg.sv @@
package aac_pkg;

  localparam int unsigned COORD_W = 48;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_CLIP_X  = 2'd0,
    KIND_CLIP_Y  = 2'd1,
    KIND_CLIP_Z  = 2'd2,
    KIND_OVERLAP = 2'd3
  } kind_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVER_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVER_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVER_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVER_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVER_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOVER_MAX_Z = 3'd5;

  typedef struct packed {
    kind_e  kind;
    coord_t obstacle_min_x;
    coord_t obstacle_min_y;
    coord_t obstacle_min_z;
    coord_t obstacle_max_x;
    coord_t obstacle_max_y;
    coord_t obstacle_max_z;
    coord_t motion_offset;
  } in_req_t;

  typedef struct packed {
    coord_t clipped_offset;
    logic   boxes_overlap;
  } out_rsp_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // after compare stage: operands of the clip axis and decisions
  typedef struct packed {
    coord_t offset;
    coord_t obs_min;
    coord_t mov_max;
    coord_t obs_max;
    coord_t mov_min;
    logic   clip_pos;
    logic   clip_neg;
    logic   overlap;
  } cmp_res_t;

  // after gap stage
  typedef struct packed {
    coord_t offset;
    coord_t gap_pos;
    coord_t gap_neg;
    logic   clip_pos;
    logic   clip_neg;
    logic   overlap;
  } gap_res_t;

  // a - b, saturated to the coordinate range
  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic signed [COORD_W:0] diff;
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    if (diff[COORD_W] != diff[COORD_W-1]) begin
      sat_sub = diff[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_sub = diff[COORD_W-1:0];
    end
  endfunction

endpackage

@@ sv/aac_cmp.sv @@
module aac_cmp import aac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  box_t     mover_i,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_req_t  req_i,
  output logic     valid_o,
  input  logic     ready_i,
  output cmp_res_t res_o
);

  logic     valid_q;
  cmp_res_t res_d, res_q;
  logic [2:0] gt;  // mover.max > obs.min
  logic [2:0] lt;  // mover.min < obs.max
  logic       side_ov;
  logic       pos, neg;

  always_comb begin
    gt[0] = mover_i.max_x > req_i.obstacle_min_x;
    gt[1] = mover_i.max_y > req_i.obstacle_min_y;
    gt[2] = mover_i.max_z > req_i.obstacle_min_z;
    lt[0] = mover_i.min_x < req_i.obstacle_max_x;
    lt[1] = mover_i.min_y < req_i.obstacle_max_y;
    lt[2] = mover_i.min_z < req_i.obstacle_max_z;
    // strictly positive: sign clear and not zero
    pos = ~req_i.motion_offset[COORD_W-1] & (|req_i.motion_offset);
    neg = req_i.motion_offset[COORD_W-1];

    res_d = '0;
    res_d.offset  = req_i.motion_offset;
    res_d.overlap = &(gt & lt);
    side_ov = 1'b0;
    case (req_i.kind)
      KIND_CLIP_X: begin
        side_ov       = gt[1] & lt[1] & gt[2] & lt[2];
        res_d.obs_min = req_i.obstacle_min_x;
        res_d.obs_max = req_i.obstacle_max_x;
        res_d.mov_min = mover_i.min_x;
        res_d.mov_max = mover_i.max_x;
        res_d.clip_pos = side_ov & pos & ~gt[0];
        res_d.clip_neg = side_ov & neg & ~lt[0];
      end
      KIND_CLIP_Y: begin
        side_ov       = gt[2] & lt[2] & gt[0] & lt[0];
        res_d.obs_min = req_i.obstacle_min_y;
        res_d.obs_max = req_i.obstacle_max_y;
        res_d.mov_min = mover_i.min_y;
        res_d.mov_max = mover_i.max_y;
        res_d.clip_pos = side_ov & pos & ~gt[1];
        res_d.clip_neg = side_ov & neg & ~lt[1];
      end
      KIND_CLIP_Z: begin
        side_ov       = gt[0] & lt[0] & gt[1] & lt[1];
        res_d.obs_min = req_i.obstacle_min_z;
        res_d.obs_max = req_i.obstacle_max_z;
        res_d.mov_min = mover_i.min_z;
        res_d.mov_max = mover_i.max_z;
        res_d.clip_pos = side_ov & pos & ~gt[2];
        res_d.clip_neg = side_ov & neg & ~lt[2];
      end
      default: begin
        // overlap test only: offset passes
        res_d.clip_pos = 1'b0;
        res_d.clip_neg = 1'b0;
      end
    endcase
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ sv/aac_gap.sv @@
module aac_gap import aac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  cmp_res_t res_i,
  output logic     valid_o,
  input  logic     ready_i,
  output gap_res_t res_o
);

  logic     valid_q;
  gap_res_t res_d, res_q;

  always_comb begin
    res_d.offset   = res_i.offset;
    res_d.gap_pos  = sat_sub(res_i.obs_min, res_i.mov_max);
    res_d.gap_neg  = sat_sub(res_i.obs_max, res_i.mov_min);
    res_d.clip_pos = res_i.clip_pos;
    res_d.clip_neg = res_i.clip_neg;
    res_d.overlap  = res_i.overlap;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ sv/aac_sel.sv @@
module aac_sel import aac_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  gap_res_t res_i,
  output logic     valid_o,
  input  logic     ready_i,
  output out_rsp_t rsp_o
);

  logic     valid_q;
  out_rsp_t rsp_d, rsp_q;

  // the two clip cases exclude each other (sign of the offset)
  always_comb begin
    rsp_d.boxes_overlap = res_i.overlap;
    if (res_i.clip_pos && (res_i.gap_pos < res_i.offset)) begin
      rsp_d.clipped_offset = res_i.gap_pos;
    end else if (res_i.clip_neg && (res_i.gap_neg > res_i.offset)) begin
      rsp_d.clipped_offset = res_i.gap_neg;
    end else begin
      rsp_d.clipped_offset = res_i.offset;
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

@@ sv/aabb_axis_clip_top.sv @@
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  request  | in_valid_i / in_ready_o    | in_req_i  (kind, obstacle, offset)
//  result   | out_valid_o / out_ready_i  | out_rsp_o (clipped offset, overlap)
//  config   | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
//  Three register stages: compare, saturating gap subtract, clip select.
//  One request per cycle is taken unless out_ready_i stalls the stage chain.
//  Each stage holds its own valid bit and loads whenever it is empty or its
//  successor advances, so a stalled result does not block upstream bubbles.
//  rst_ni clears the valid bits and the mover box to zero.
module aabb_axis_clip_top import aac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  coord_t               cfg_data_i,
  // request
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  // result
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_rsp_t             out_rsp_o
);

  box_t     mover_q;

  logic     cmp_valid, cmp_ready;
  cmp_res_t cmp_res;
  logic     gap_valid, gap_ready;
  gap_res_t gap_res;

  // mover box registers; indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mover_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOVER_MIN_X: mover_q.min_x <= cfg_data_i;
        REG_MOVER_MIN_Y: mover_q.min_y <= cfg_data_i;
        REG_MOVER_MIN_Z: mover_q.min_z <= cfg_data_i;
        REG_MOVER_MAX_X: mover_q.max_x <= cfg_data_i;
        REG_MOVER_MAX_Y: mover_q.max_y <= cfg_data_i;
        REG_MOVER_MAX_Z: mover_q.max_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: per-axis strict overlap, clip axis select
  aac_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mover_i (mover_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .valid_o (cmp_valid),
    .ready_i (cmp_ready),
    .res_o   (cmp_res)
  );

  // stage 2: both gaps, saturated
  aac_gap u_gap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmp_valid),
    .ready_o (cmp_ready),
    .res_i   (cmp_res),
    .valid_o (gap_valid),
    .ready_i (gap_ready),
    .res_o   (gap_res)
  );

  // stage 3: limit offset, output register
  aac_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gap_valid),
    .ready_o (gap_ready),
    .res_i   (gap_res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule
